// File: src/mdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdd_pkg
// Shared types for the max drawdown tracker: controller states and the
// command and status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mdd_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_CMP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic compare;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic skip_div;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

// File: src/mdd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdd_ctrl
// Sequencer for one request: capture, divider setup, serial divide, compare
// against the held maximum unless skipped, and handoff to the output register.
// ----------------------------------------------------------------------------
module mdd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  mdd_pkg::t_status i_status,
    output mdd_pkg::t_cmd    o_cmd
);
    import mdd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = i_status.skip_div ? S_OUT : S_DIV;
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
            end
            S_OUT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_div_exits_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_status.div_last) |=> (r_state == S_CMP))
        else $error("divider finish did not reach compare");
    a_skip_goes_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP && i_status.skip_div) |=> (r_state == S_OUT))
        else $error("skipped divide did not reach output");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command");
`endif

endmodule

// File: src/mdd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdd_datapath
// Tracking state, restoring serial divider for the drawdown fraction, and the
// output register.
// ----------------------------------------------------------------------------
module mdd_datapath #(
    parameter int INDEX_WIDTH   = 24,
    parameter int SAMPLE_WIDTH  = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mdd_pkg::t_cmd            i_cmd,
    output mdd_pkg::t_status         o_status,
    input  logic [SAMPLE_WIDTH-1:0]  i_equity,
    input  logic                     i_start_req,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [SAMPLE_WIDTH-1:0]  o_drawdown_amount,
    output logic [FRACTION_BITS:0]   o_drawdown_fraction,
    output logic [INDEX_WIDTH-1:0]   o_peak_position,
    output logic [INDEX_WIDTH-1:0]   o_trough_position,
    output logic [INDEX_WIDTH-1:0]   o_recovery_position,
    output logic                     o_zero_peak_flag
);
    import mdd_pkg::*;

    localparam int CntWidth = $clog2(FRACTION_BITS);
    localparam logic [CntWidth-1:0] CntLast = CntWidth'(FRACTION_BITS - 1);
    localparam logic [FRACTION_BITS:0] FracOne = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [INDEX_WIDTH-1:0] IdxMax = {INDEX_WIDTH{1'b1}};

    logic [SAMPLE_WIDTH-1:0]  r_peak;
    logic [INDEX_WIDTH-1:0]   r_peak_pos;
    logic [INDEX_WIDTH-1:0]   r_count;
    logic [FRACTION_BITS:0]   r_best_frac;
    logic [SAMPLE_WIDTH-1:0]  r_best_amount;
    logic [INDEX_WIDTH-1:0]   r_best_peak_pos;
    logic [INDEX_WIDTH-1:0]   r_best_trough_pos;
    logic [INDEX_WIDTH-1:0]   r_recovery;
    logic                     r_zero_seen;

    logic [SAMPLE_WIDTH-1:0]  r_eq;
    logic                     r_start;
    logic [SAMPLE_WIDTH-1:0]  r_diff;
    logic [SAMPLE_WIDTH-1:0]  r_rem;
    logic [FRACTION_BITS-1:0] r_quo;
    logic [CntWidth-1:0]      r_cnt;
    logic                     r_full;

    logic                     r_out_valid;
    logic [SAMPLE_WIDTH-1:0]  r_out_amount;
    logic [FRACTION_BITS:0]   r_out_frac;
    logic [INDEX_WIDTH-1:0]   r_out_peak_pos;
    logic [INDEX_WIDTH-1:0]   r_out_trough_pos;
    logic [INDEX_WIDTH-1:0]   r_out_recovery;
    logic                     r_out_zero;

    logic [INDEX_WIDTH-1:0]   n_idx;
    logic [SAMPLE_WIDTH:0]    rem_shift;
    logic                     rem_ge;
    logic [FRACTION_BITS:0]   frac_new;

    assign n_idx     = (r_count == IdxMax) ? r_count : r_count + 1'b1;
    assign rem_shift = {r_rem, 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, r_peak};
    assign frac_new  = r_full ? FracOne : {1'b0, r_quo};

    assign o_status.skip_div = r_start || (r_peak == '0);
    assign o_status.div_last = (r_cnt == CntLast);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    // tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak            <= '0;
            r_peak_pos        <= '0;
            r_count           <= '0;
            r_best_frac       <= '0;
            r_best_amount     <= '0;
            r_best_peak_pos   <= '0;
            r_best_trough_pos <= '0;
            r_recovery        <= '0;
            r_zero_seen       <= 1'b0;
        end else if (i_cmd.load) begin
            if (i_start_req) begin
                r_peak            <= i_equity;
                r_peak_pos        <= '0;
                r_count           <= '0;
                r_best_frac       <= '0;
                r_best_amount     <= '0;
                r_best_peak_pos   <= '0;
                r_best_trough_pos <= '0;
                r_recovery        <= '0;
                r_zero_seen       <= 1'b0;
            end else begin
                r_count <= n_idx;
                if (i_equity > r_peak) begin
                    r_peak     <= i_equity;
                    r_peak_pos <= n_idx;
                end
                if (i_equity == '0 && r_peak == '0) begin
                    r_zero_seen <= 1'b1;
                end
                // a sample at or above the peak never sets a new drawdown
                if (i_equity >= r_peak && r_best_frac != '0 && r_recovery == '0) begin
                    r_recovery <= n_idx;
                end
            end
        end else if (i_cmd.compare) begin
            if (frac_new > r_best_frac) begin
                r_best_frac       <= frac_new;
                r_best_amount     <= r_diff;
                r_best_peak_pos   <= r_peak_pos;
                r_best_trough_pos <= r_count;
            end
        end
    end

    // divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_eq    <= i_equity;
            r_start <= i_start_req;
        end
        if (i_cmd.prep) begin
            r_diff <= r_peak - r_eq;
            r_rem  <= r_peak - r_eq;
            r_quo  <= '0;
            r_full <= (r_eq == '0);
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[FRACTION_BITS-2:0], rem_ge};
            if (rem_ge) begin
                r_rem <= SAMPLE_WIDTH'(rem_shift - {1'b0, r_peak});
            end else begin
                r_rem <= rem_shift[SAMPLE_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.prep) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_amount     <= r_best_amount;
            r_out_frac       <= r_best_frac;
            r_out_peak_pos   <= r_best_peak_pos;
            r_out_trough_pos <= r_best_trough_pos;
            r_out_recovery   <= r_recovery;
            r_out_zero       <= r_zero_seen;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_drawdown_amount   = r_out_amount;
    assign o_drawdown_fraction = r_out_frac;
    assign o_peak_position     = r_out_peak_pos;
    assign o_trough_position   = r_out_trough_pos;
    assign o_recovery_position = r_out_recovery;
    assign o_zero_peak_flag    = r_out_zero;

`ifndef SYNTHESIS
    a_frac_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_frac <= FracOne)
        else $error("held fraction above full loss");
    a_trough_after_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_trough_pos >= r_best_peak_pos)
        else $error("trough index before peak index");
    a_rem_below_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && !r_full) |-> (r_rem < r_peak))
        else $error("divider remainder not below divisor");
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("emitted result not presented");
`endif

endmodule

// File: src/max_drawdown_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_drawdown_tracker
// Streaming maximum drawdown tracker: running peak, largest relative drawdown
// as a Q1.FRACTION_BITS fraction with its peak, trough and recovery indices.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): one equity sample per request,
//   i_start_req marks the first sample of a new curve and clears tracking.
//   Output channel (o_out_valid / i_out_stall): one summary per request,
//   in request order.
//   A request with a divide passes from acceptance through divider setup,
//   the serial divide and the compare to the output state, which loads the
//   output register; a start sample or a sample while the peak is zero goes
//   from setup straight to the output state. The serial restoring divider
//   makes one quotient bit per cycle. One request is in work at a time.
//   The input is taken again as soon as a result has moved to the output
//   register, even while that result still waits for the receiver.
//   When the receiver stalls, the output holds; a finished request then
//   waits in the controller and the input stays stalled until it moves.
//   Reset (synchronous, active low) clears all tracking and empties the
//   output register; the first sample without a start flag gets index 1.
// ----------------------------------------------------------------------------
module max_drawdown_tracker #(
    parameter int INDEX_WIDTH   = 24,
    parameter int SAMPLE_WIDTH  = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [SAMPLE_WIDTH-1:0]  i_equity,
    input  logic                     i_start_req,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [SAMPLE_WIDTH-1:0]  o_drawdown_amount,
    output logic [FRACTION_BITS:0]   o_drawdown_fraction,
    output logic [INDEX_WIDTH-1:0]   o_peak_position,
    output logic [INDEX_WIDTH-1:0]   o_trough_position,
    output logic [INDEX_WIDTH-1:0]   o_recovery_position,
    output logic                     o_zero_peak_flag
);
    import mdd_pkg::*;

    t_cmd    cmd;
    t_status status;

    mdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mdd_datapath #(
        .INDEX_WIDTH   (INDEX_WIDTH),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_equity            (i_equity),
        .i_start_req         (i_start_req),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_drawdown_amount   (o_drawdown_amount),
        .o_drawdown_fraction (o_drawdown_fraction),
        .o_peak_position     (o_peak_position),
        .o_trough_position   (o_trough_position),
        .o_recovery_position (o_recovery_position),
        .o_zero_peak_flag    (o_zero_peak_flag)
    );

endmodule
